[src/tbsr_pkg.sv]
// Shared types and constants for the text byte stream recoder.
// Used by the front classifier, the item queue, the back emitter and the top level.
package tbsr_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] REG_LATIN1 = 2'd0;
   localparam logic [1:0] REG_PAIR   = 2'd1;
   localparam logic [1:0] REG_DROP   = 2'd2;
   localparam logic [1:0] REG_LIMIT  = 2'd3;
   localparam int unsigned REG_COUNT = 4;

   // pair mode codes
   localparam logic [2:0] PAIR_NONE         = 3'd0;
   localparam logic [2:0] PAIR_ASCII_LITTLE = 3'd1;
   localparam logic [2:0] PAIR_ASCII_BIG    = 3'd2;
   localparam logic [2:0] PAIR_UTF8_LITTLE  = 3'd3;

   localparam logic [7:0]  SPACE_BYTE  = 8'h20;
   localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

   // configuration seen by the datapath
   typedef struct packed {
      logic        latin1_expand;
      logic [2:0]  pair_mode;
      logic        drop_spaces;
      logic [31:0] output_limit;
   } cfg_type;

   // one queued item: end marker, or one or two candidate bytes
   typedef struct packed {
      logic       is_end;
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } entry_type;

endpackage

[src/tbsr_front.sv]
// Front classifier: accepts input items, decodes characters, builds queue entries.
// Depends on tbsr_pkg for the configuration and entry types.
module tbsr_front (
   input  logic                clock,
   input  logic                reset,
   input  tbsr_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          raw_byte,
   input  logic                stream_end,
   input  logic                queue_full,
   output logic                push,
   output tbsr_pkg::entry_type entry
);
   import tbsr_pkg::*;

   // only the low 16 code point bits are ever emitted, so keep just those
   logic [15:0] accum_ff, accum_in;
   logic [2:0]  pending_ff, pending_in;
   logic        accept;
   logic        little;
   logic [15:0] pair_cp;
   logic        emit_pair;
   logic [15:0] shifted;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign little   = (cfg.pair_mode == PAIR_ASCII_LITTLE) ||
                     (cfg.pair_mode == PAIR_UTF8_LITTLE);
   assign shifted  = {accum_ff[9:0], raw_byte[5:0]};

   // classify the item and work out the next decoder state
   always_comb begin
      accum_in    = accum_ff;
      pending_in  = pending_ff;
      entry       = '0;
      emit_pair   = 1'b0;
      pair_cp     = 16'd0;
      if (stream_end) begin
         accum_in     = 16'd0;
         pending_in   = 3'd0;
         entry.is_end = 1'b1;
      end else if (cfg.latin1_expand || cfg.pair_mode == PAIR_NONE) begin
         accum_in   = 16'd0;
         pending_in = 3'd0;
         if (cfg.drop_spaces && raw_byte == SPACE_BYTE) begin
            entry.count = 2'd0;
         end else if (cfg.latin1_expand && raw_byte[7]) begin
            entry.count = 2'd2;
            entry.byte0 = {6'b110000, raw_byte[7:6]};
            entry.byte1 = {2'b10, raw_byte[5:0]};
         end else begin
            entry.count = 2'd1;
            entry.byte0 = raw_byte;
         end
      end else if (cfg.pair_mode == PAIR_ASCII_LITTLE || cfg.pair_mode == PAIR_ASCII_BIG) begin
         accum_in   = 16'd0;
         pending_in = 3'd0;
         emit_pair  = 1'b1;
         pair_cp    = {8'd0, raw_byte};
      end else if (pending_ff != 3'd0) begin
         if (raw_byte[7:6] == 2'b10) begin
            // continuation: gather six more bits
            pending_in = pending_ff - 3'd1;
            if (pending_ff == 3'd1) begin
               emit_pair = 1'b1;
               pair_cp   = shifted;
               accum_in  = 16'd0;
            end else begin
               accum_in  = shifted;
            end
         end else begin
            // bad continuation: close the character, drop the byte
            emit_pair  = 1'b1;
            pair_cp    = accum_ff;
            accum_in   = 16'd0;
            pending_in = 3'd0;
         end
      end else if (raw_byte[7:5] == 3'b110) begin
         accum_in   = {11'd0, raw_byte[4:0]};
         pending_in = 3'd1;
      end else if (raw_byte[7:4] == 4'b1110) begin
         accum_in   = {12'd0, raw_byte[3:0]};
         pending_in = 3'd2;
      end else if (raw_byte[7:3] == 5'b11110) begin
         accum_in   = {13'd0, raw_byte[2:0]};
         pending_in = 3'd3;
      end else if (raw_byte[7:2] == 6'b111110) begin
         accum_in   = {14'd0, raw_byte[1:0]};
         pending_in = 3'd4;
      end else if (raw_byte[7:1] == 7'b1111110) begin
         accum_in   = {15'd0, raw_byte[0]};
         pending_in = 3'd5;
      end else begin
         // ASCII or stray byte stands as its own character
         emit_pair = 1'b1;
         pair_cp   = {8'd0, raw_byte};
      end
      if (emit_pair) begin
         entry.count = 2'd2;
         entry.byte0 = little ? pair_cp[7:0] : pair_cp[15:8];
         entry.byte1 = little ? pair_cp[15:8] : pair_cp[7:0];
      end
   end

   // queue only items that cause a result
   assign push = accept && (entry.is_end || entry.count != 2'd0);

   // hold decoder state between items
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= 16'd0;
         pending_ff <= 3'd0;
      end else if (accept) begin
         accum_ff   <= accum_in;
         pending_ff <= pending_in;
      end
   end

endmodule

[src/tbsr_queue.sv]
// Short item queue between the front classifier and the back emitter.
// Depends on tbsr_pkg for the entry type.
module tbsr_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tbsr_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tbsr_pkg::entry_type head_entry
);
   import tbsr_pkg::*;

   localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);

   entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full       = (fill_ff == FILL_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/tbsr_back.sv]
// Back emitter: sends queued bytes one per cycle while the receiver is ready, under the output byte limit.
// Depends on tbsr_pkg for the entry type.
module tbsr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         output_limit,
   input  logic                head_valid,
   input  tbsr_pkg::entry_type head_entry,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                out_end,
   output logic                out_last
);
   import tbsr_pkg::*;

   logic        phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        last_ff, last_in;
   logic        load_ok, emit;
   logic        pass_now, pass_next;

   assign load_ok   = !valid_ff || out_ready;
   assign pass_now  = count_ff < output_limit;
   assign pass_next = ({1'b0, count_ff} + 33'd1) < {1'b0, output_limit};

   // pick the next byte slot of the head entry
   always_comb begin
      pop      = 1'b0;
      emit     = 1'b0;
      phase_in = phase_ff;
      count_in = count_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (head_valid && load_ok) begin
         if (head_entry.is_end) begin
            emit     = 1'b1;
            byte_in  = 8'd0;
            end_in   = 1'b1;
            last_in  = 1'b1;
            pop      = 1'b1;
            count_in = 32'd0;
            phase_in = 1'b0;
         end else if (!phase_ff) begin
            if (pass_now) begin
               emit     = 1'b1;
               byte_in  = head_entry.byte0;
               end_in   = 1'b0;
               last_in  = !(head_entry.count == 2'd2 && pass_next);
               count_in = count_ff + 32'd1;
            end
            if (head_entry.count == 2'd2) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            if (pass_now) begin
               emit     = 1'b1;
               byte_in  = head_entry.byte1;
               end_in   = 1'b0;
               last_in  = 1'b1;
               count_in = count_ff + 32'd1;
            end
            pop      = 1'b1;
            phase_in = 1'b0;
         end
      end
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         count_ff <= 32'd0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;
   assign out_last  = last_ff;

endmodule

[src/text_byte_stream_recoder_core.sv]
// Text byte stream recoder: passes, Latin-1 expands or UTF-8/ASCII pair-encodes a byte
// stream, with optional space dropping and an output byte limit. Input items are taken
// one per cycle while the item queue has room; the emitter sends one result byte per
// cycle while the receiver is ready, so an item giving two bytes is sent byte by byte
// before the next item starts. Items that give no result never reach the emitter; an
// item whose bytes are all held back by the limit still steps through the emitter.
// Depends on tbsr_pkg, tbsr_front, tbsr_queue and tbsr_back.
module text_byte_stream_recoder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_raw_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_end_marker,
   output logic        rsp_run_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tbsr_pkg::*;

   cfg_type     cfg_ff;
   logic        cfg_write;
   logic [1:0]  reg_index;
   logic        reg_in_range;
   logic        push, pop, full, head_valid;
   entry_type   push_entry, head_entry;

   // configuration registers
   assign csr_pready   = 1'b1;
   assign cfg_write    = csr_psel && csr_penable && csr_pwrite;
   assign reg_index    = csr_paddr[3:2];
   assign reg_in_range = (csr_paddr[1:0] == 2'd0) && ({30'd0, reg_index} < REG_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.latin1_expand <= 1'b0;
         cfg_ff.pair_mode     <= PAIR_NONE;
         cfg_ff.drop_spaces   <= 1'b0;
         cfg_ff.output_limit  <= LIMIT_RESET;
      end else if (cfg_write && reg_in_range) begin
         case (reg_index)
            REG_LATIN1: cfg_ff.latin1_expand <= csr_pwdata[0];
            REG_PAIR:   cfg_ff.pair_mode     <= csr_pwdata[2:0];
            REG_DROP:   cfg_ff.drop_spaces   <= csr_pwdata[0];
            REG_LIMIT:  cfg_ff.output_limit  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (reg_in_range) begin
         case (reg_index)
            REG_LATIN1: csr_prdata = {31'd0, cfg_ff.latin1_expand};
            REG_PAIR:   csr_prdata = {29'd0, cfg_ff.pair_mode};
            REG_DROP:   csr_prdata = {31'd0, cfg_ff.drop_spaces};
            REG_LIMIT:  csr_prdata = cfg_ff.output_limit;
            default:    csr_prdata = 32'd0;
         endcase
      end
   end

   tbsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .raw_byte   (req_raw_byte),
      .stream_end (req_stream_end),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   tbsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tbsr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .output_limit (cfg_ff.output_limit),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .pop          (pop),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_byte     (rsp_text_byte),
      .out_end      (rsp_end_marker),
      .out_last     (rsp_run_last)
   );

endmodule

[verif/text_byte_stream_recoder_core_tb.sv]
// Testbench for text_byte_stream_recoder_core: directed and random byte streams in every
// recoding mode, each result checked against a built-in predictor of the recoder.
// Depends on tbsr_pkg and the text_byte_stream_recoder_core RTL.
module text_byte_stream_recoder_core_tb;
   import tbsr_pkg::*;

   localparam logic [2:0] PAIR_UTF8_BIG  = 3'd4;
   localparam logic [2:0] PAIR_UNDEF_TOP = 3'd7;
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned RANDOM_ITEMS  = 1500;
   localparam int unsigned PHASE_ITEMS   = 100;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_marker;
      logic       run_last;
   } text_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_raw_byte = 8'h00;
   logic        req_stream_end = 1'b0;
   logic        rsp_ready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_text_byte;
   logic        rsp_end_marker;
   logic        rsp_run_last;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the configuration and decode state
   logic        cfg_latin1 = 1'b0;
   logic [2:0]  cfg_pair = PAIR_NONE;
   logic        cfg_drop = 1'b0;
   logic [31:0] cfg_limit = LIMIT_RESET;
   logic [30:0] code_bits = '0;
   logic [2:0]  cont_left = '0;
   logic [31:0] stream_byte_count = '0;

   text_result_type expected_bytes[$];
   int unsigned     error_count = 0;
   int unsigned     items_sent = 0;
   bit              stall_free = 1'b0;

   text_byte_stream_recoder_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_byte   (req_raw_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_end_marker (rsp_end_marker),
      .rsp_run_last   (rsp_run_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // queue one output byte unless the output limit holds it back
   function automatic void push_text_byte(input logic [7:0] value);
      if (stream_byte_count < cfg_limit) begin
         stream_byte_count++;
         expected_bytes.push_back('{text_byte: value, end_marker: 1'b0, run_last: 1'b0});
      end
   endfunction

   function automatic void push_code_pair(input logic [15:0] code, input bit little);
      if (little) begin
         push_text_byte(code[7:0]);
         push_text_byte(code[15:8]);
      end else begin
         push_text_byte(code[15:8]);
         push_text_byte(code[7:0]);
      end
   endfunction

   // work out the results of one accepted item and advance the decode state
   function automatic void predict_recoded(input logic [7:0] b, input logic at_end);
      int unsigned     mark;
      logic [2:0]      extra;
      logic [30:0]     lead;
      bit              little;
      text_result_type tail;
      mark = expected_bytes.size();
      little = (cfg_pair == PAIR_UTF8_LITTLE);
      if (at_end) begin
         code_bits = '0;
         cont_left = '0;
         stream_byte_count = '0;
         expected_bytes.push_back('{text_byte: 8'h00, end_marker: 1'b1, run_last: 1'b1});
      end else if (cfg_latin1 || cfg_pair == PAIR_NONE) begin
         code_bits = '0;
         cont_left = '0;
         if (!(cfg_drop && b == SPACE_BYTE)) begin
            if (cfg_latin1 && b[7]) begin
               push_text_byte({6'b110000, b[7:6]});
               push_text_byte({2'b10, b[5:0]});
            end else begin
               push_text_byte(b);
            end
         end
      end else if (cfg_pair == PAIR_ASCII_LITTLE || cfg_pair == PAIR_ASCII_BIG) begin
         code_bits = '0;
         cont_left = '0;
         push_code_pair({8'h00, b}, cfg_pair == PAIR_ASCII_LITTLE);
      end else if (cont_left != 0) begin
         if (b[7:6] == 2'b10) begin
            code_bits = {code_bits[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 0) begin
               push_code_pair(code_bits[15:0], little);
               code_bits = '0;
            end
         end else begin
            // bad continuation: flush what was gathered, drop the byte
            push_code_pair(code_bits[15:0], little);
            code_bits = '0;
            cont_left = '0;
         end
      end else begin
         extra = 3'd0;
         lead = '0;
         if (b[7:5] == 3'b110) begin
            lead = {26'd0, b[4:0]};
            extra = 3'd1;
         end else if (b[7:4] == 4'b1110) begin
            lead = {27'd0, b[3:0]};
            extra = 3'd2;
         end else if (b[7:3] == 5'b11110) begin
            lead = {28'd0, b[2:0]};
            extra = 3'd3;
         end else if (b[7:2] == 6'b111110) begin
            lead = {29'd0, b[1:0]};
            extra = 3'd4;
         end else if (b[7:1] == 7'b1111110) begin
            lead = {30'd0, b[0]};
            extra = 3'd5;
         end
         if (extra != 0) begin
            code_bits = lead;
            cont_left = extra;
         end else begin
            // ASCII, stray continuation or 0xFE/0xFF stands as itself
            push_code_pair({8'h00, b}, little);
         end
      end
      if (expected_bytes.size() > mark) begin
         tail = expected_bytes.pop_back();
         tail.run_last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endfunction

   // track register writes, predict accepted items, check returned items
   always @(posedge clock) begin : result_check
      text_result_type want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_LATIN1: cfg_latin1 = csr_pwdata[0];
               REG_PAIR:   cfg_pair = csr_pwdata[2:0];
               REG_DROP:   cfg_drop = csr_pwdata[0];
               REG_LIMIT:  cfg_limit = csr_pwdata;
               default:    ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_recoded(req_raw_byte, req_stream_end);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected item byte %02h end %0b last %0b",
                  rsp_text_byte, rsp_end_marker, rsp_run_last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_text_byte !== want.text_byte) begin
                  report_mismatch($sformatf("text_byte %02h, want %02h",
                     rsp_text_byte, want.text_byte));
               end
               if (rsp_end_marker !== want.end_marker) begin
                  report_mismatch($sformatf("end_marker %0b, want %0b",
                     rsp_end_marker, want.end_marker));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %0b, want %0b",
                     rsp_run_last, want.run_last));
               end
            end
         end
      end
   end

   // receiver: stall for a random gap before taking each item, unless stall_free is set
   initial begin : result_sink
      int unsigned gap;
      do @(negedge clock); while (reset);
      forever begin
         gap = stall_free ? 0 : $urandom_range(0, 17);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // send one item; entered and left at a falling edge, valid left high
   task automatic send_byte(input logic [7:0] value, input logic at_end);
      int unsigned gap;
      gap = stall_free ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_byte <= value;
      req_stream_end <= at_end;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid and hold until every predicted item has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_bytes.size() != 0);
   endtask

   // write one register, then read it back
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] want;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_LATIN1, REG_DROP: want = {31'd0, value[0]};
         REG_PAIR:             want = {29'd0, value[2:0]};
         default:              want = value;
      endcase
      if (readback !== want) begin
         report_mismatch($sformatf("register %0d reads %08h, want %08h", index, readback, want));
      end
   endtask

   // settle the block, then write every register; garble fills unused upper bits
   task automatic set_recoder_mode(input logic latin1, input logic [2:0] pair,
                                   input logic drop, input logic [31:0] limit,
                                   input bit garble);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(REG_LATIN1, {garble ? 31'($urandom) : 31'd0, latin1});
      write_reg(REG_PAIR, {garble ? 29'($urandom) : 29'd0, pair});
      write_reg(REG_DROP, {garble ? 31'($urandom) : 31'd0, drop});
      write_reg(REG_LIMIT, limit);
   endtask

   task automatic test_plain_and_latin1();
      // reset defaults: plain pass-through
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // Latin-1 expansion wins over a pair mode; spaces dropped
      set_recoder_mode(1'b1, PAIR_UTF8_BIG, 1'b1, LIMIT_RESET, 1'b0);
      send_byte(SPACE_BYTE, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
   endtask

   task automatic test_ascii_pairs();
      // ASCII pairs with drop set, then a space in big endian pairs with drop clear
      set_recoder_mode(1'b0, PAIR_ASCII_LITTLE, 1'b1, LIMIT_RESET, 1'b0);
      send_byte(8'hA5, 1'b0);
      set_recoder_mode(1'b0, PAIR_ASCII_BIG, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(SPACE_BYTE, 1'b0);
   endtask

   task automatic test_utf8_pairs();
      set_recoder_mode(1'b0, PAIR_UTF8_LITTLE, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      // stray continuation, stray 0xFE, bad continuation
      set_recoder_mode(1'b0, PAIR_UTF8_BIG, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      // undefined pair mode acts as big endian UTF-8
      set_recoder_mode(1'b0, PAIR_UNDEF_TOP, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
   endtask

   task automatic test_mode_change_and_end();
      // partial character dropped at end of stream
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h00, 1'b1);
      // plain mode clears a pending character
      set_recoder_mode(1'b0, PAIR_UTF8_BIG, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(8'hE2, 1'b0);
      set_recoder_mode(1'b0, PAIR_NONE, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(8'h41, 1'b0);
      set_recoder_mode(1'b0, PAIR_UTF8_BIG, 1'b0, LIMIT_RESET, 1'b0);
      send_byte(8'h82, 1'b0);
   endtask

   task automatic test_output_limit();
      // three bytes allowed: second pair is cut after its first byte
      set_recoder_mode(1'b0, PAIR_UTF8_LITTLE, 1'b0, 32'd3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic send_utf8_char();
      int unsigned kind;
      int unsigned len;
      int unsigned keep;
      logic [7:0]  lead;
      logic [7:0]  bad;
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 6);
      case (len)
         1:       lead = {1'b0, 7'($urandom)};
         2:       lead = {3'b110, 5'($urandom)};
         3:       lead = {4'b1110, 4'($urandom)};
         4:       lead = {5'b11110, 3'($urandom)};
         5:       lead = {6'b111110, 2'($urandom)};
         default: lead = {7'b1111110, 1'($urandom)};
      endcase
      if (kind < 12) begin
         // stray byte
         if ($urandom_range(0, 2) == 0) begin
            send_byte({7'b1111111, 1'($urandom)}, 1'b0);
         end else begin
            send_byte({2'b10, 6'($urandom)}, 1'b0);
         end
      end else if (kind < 20) begin
         send_byte(8'($urandom), 1'b0);
      end else begin
         keep = len - 1;
         if (kind < 40 && len > 1) begin
            keep = $urandom_range(0, len - 2);
         end
         send_byte(lead, 1'b0);
         repeat (keep) send_byte({2'b10, 6'($urandom)}, 1'b0);
         if (keep < len - 1) begin
            // cut short: end of stream or a bad continuation
            if (kind < 26) begin
               send_byte(8'($urandom), 1'b1);
            end else begin
               bad = 8'($urandom);
               if (bad[7:6] == 2'b10) begin
                  bad[6] = 1'b1;
               end
               send_byte(bad, 1'b0);
            end
         end
      end
   endtask

   task automatic send_text_fragment();
      int unsigned end_pct;
      end_pct = (cfg_limit < 64) ? 10 : 3;
      if ($urandom_range(0, 99) < end_pct) begin
         send_byte(8'($urandom), 1'b1);
      end else if (!cfg_latin1 && cfg_pair >= PAIR_UTF8_LITTLE) begin
         send_utf8_char();
      end else if ($urandom_range(0, 4) == 0) begin
         send_byte(SPACE_BYTE, 1'b0);
      end else begin
         send_byte(8'($urandom), 1'b0);
      end
   endtask

   task automatic test_random_streams();
      int unsigned phase;
      int unsigned target;
      int unsigned start;
      logic        latin1;
      logic [2:0]  pair;
      logic        drop;
      logic [31:0] limit;
      phase = 0;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         // extremes first, then random settings
         case (phase)
            0: begin latin1 = 1'b1; pair = PAIR_UNDEF_TOP; drop = 1'b1; limit = LIMIT_RESET; end
            1: begin latin1 = 1'b0; pair = PAIR_NONE; drop = 1'b0; limit = 32'd0; end
            2: begin latin1 = 1'b0; pair = PAIR_UTF8_LITTLE; drop = 1'b1; limit = LIMIT_RESET; end
            3: begin
               latin1 = 1'b0;
               pair = PAIR_UTF8_BIG;
               drop = 1'b0;
               limit = 32'($urandom_range(1, 24));
            end
            default: begin
               latin1 = ($urandom_range(0, 3) == 0);
               pair = $urandom_range(0, 1) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
               drop = 1'($urandom);
               case ($urandom_range(0, 3))
                  0:       limit = 32'($urandom_range(0, 40));
                  1:       limit = $urandom;
                  default: limit = LIMIT_RESET;
               endcase
            end
         endcase
         set_recoder_mode(latin1, pair, drop, limit, phase >= 4);
         stall_free = (phase % 4 == 2);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS && items_sent < target) begin
            if (phase == 3 && items_sent - start >= PHASE_ITEMS / 2
                && items_sent - start < PHASE_ITEMS / 2 + 6) begin
               hold_until_drained();
            end
            send_text_fragment();
         end
         phase++;
      end
      stall_free = 1'b0;
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_plain_and_latin1();
      test_ascii_pairs();
      test_utf8_pairs();
      test_mode_change_and_end();
      test_output_limit();
      test_random_streams();
      // let the last items through, then give the block time to go quiet
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("text_byte_stream_recoder_core verification clean");
      end else begin
         $display("text_byte_stream_recoder_core verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("text_byte_stream_recoder_core verification failed");
      $finish;
   end

endmodule

[filelist.f]
src/tbsr_pkg.sv
src/tbsr_front.sv
src/tbsr_queue.sv
src/tbsr_back.sv
src/text_byte_stream_recoder_core.sv
verif/text_byte_stream_recoder_core_tb.sv
